// ----- design/assert_macros.svh -----
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- design/spc_pkg.sv -----
// ---------------------------------------------------------------------------
// spc_pkg
// Shared types and constants of the serial port channel.
// ---------------------------------------------------------------------------
`default_nettype none
package spc_pkg;
    localparam logic [1:0] REQ_TICK = 2'd0;
    localparam logic [1:0] REQ_READ = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;
    localparam logic [1:0] REQ_RESP = 2'd3;
    localparam logic [2:0] SEL_DATA = 3'd0;
    localparam logic [2:0] SEL_STAT = 3'd1;
    localparam logic [2:0] SEL_MODE = 3'd2;
    localparam logic [2:0] SEL_CTRL = 3'd3;
    localparam logic [2:0] SEL_BAUD = 3'd4;
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_PAD = 2'd1;
    localparam logic [1:0] KIND_CARD = 2'd2;
    localparam logic [7:0] BYTE_PAD = 8'h01;
    localparam logic [7:0] BYTE_CARD = 8'h81;
    localparam logic [10:0] DSR_PAD = 11'd500;
    localparam logic [10:0] DSR_CARD = 11'd1800;
    localparam logic [20:0] BAUD_MAX = 21'h1FFFFF;
    localparam int IS_PAD_PORT_DEF = 1;
    localparam int RX_DEPTH_DEF = 8;

    typedef struct packed {
        logic        resp_dsr;
        logic [7:0]  resp_byte;
        logic [15:0] write_value;
        logic [2:0]  access_size;
        logic [2:0]  reg_sel;
        logic [1:0]  req_type;
    } item_t;

    typedef struct packed {
        logic        partner_reset;
        logic        partner_slot;
        logic [1:0]  partner_call;
        logic [7:0]  tx_byte;
        logic        tx_done;
        logic        irq_pulse;
        logic [31:0] read_data;
    } result_t;
endpackage
`default_nettype wire

// ----- design/spc_core.sv -----
// ---------------------------------------------------------------------------
// spc_core
// Channel state and the single-pass update for one transfer.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module spc_core #(
    parameter int IS_PAD_PORT = 1
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            item_valid,
    input  wire spc_pkg::item_t  item,
    output spc_pkg::result_t     result
);
    import spc_pkg::*;

    localparam logic PAD = (IS_PAD_PORT != 0);

    logic [15:0] baud_reg, baud_next, mode_reg, mode_next;
    logic [13:0] ctrl_reg, ctrl_next;
    logic [20:0] bcnt_reg, bcnt_next;
    logic [7:0]  flags_reg, flags_next;
    logic [7:0]  hold_reg, hold_next, shift_reg, shift_next;
    logic        hfull_reg, hfull_next, armed_reg, armed_next;
    logic        busy_reg, busy_next, dwait_reg, dwait_next;
    logic        pend_reg, pend_next;
    logic [25:0] tleft_reg, tleft_next;
    logic [7:0]  rx_reg [8];
    logic [7:0]  rx_next [8];
    logic [2:0]  head_reg, head_next;
    logic [3:0]  fill_reg, fill_next;
    logic [1:0]  erl_reg, erl_next;
    logic [7:0]  last_reg, last_next;
    logic [10:0] dcnt_reg, dcnt_next;
    logic [1:0]  kind_reg, kind_next;

    logic [21:0] mul_r;
    logic [20:0] reload_v;
    logic [21:0] bmul;
    logic [21:0] bitc;
    logic        bitz;

    always_comb begin
        unique case (mode_reg[1:0])
            2'd2:    mul_r = PAD ? {2'b0, baud_reg, 4'b0} : {6'b0, baud_reg};
            2'd3:    mul_r = PAD ? {baud_reg, 6'b0} : {6'b0, baud_reg};
            default: mul_r = {6'b0, baud_reg};
        endcase
        reload_v = mul_r[21:1];
        unique case (mode_reg[1:0])
            2'd2:    bmul = {2'b0, baud_reg, 4'b0};
            2'd3:    bmul = {baud_reg, 6'b0};
            default: bmul = {6'b0, baud_reg};
        endcase
        bitz = !PAD && mode_reg[1:0] == 2'd0;
        bitc = {bmul[21:1], 1'b0};
        if (PAD) begin
            if (bitc == 22'd0) bitc = 22'd1;
        end else begin
            unique case (mode_reg[1:0])
                2'd2:    if (bitc < 22'd16) bitc = 22'd16;
                2'd3:    if (bitc < 22'd64) bitc = 22'd64;
                default: if (bitc == 22'd0) bitc = 22'd1;
            endcase
        end
    end

    always_comb begin
        logic        go;
        logic [25:0] tc;
        logic [3:0]  thr;
        logic        irq_c;
        logic [2:0]  n;
        logic [3:0]  rem;
        logic [3:0]  take;
        logic [7:0]  b;
        logic        pushv;
        logic [7:0]  pbyte;
        logic [21:0] wmul;
        go = 1'b0; tc = '0; thr = '0; irq_c = 1'b0; n = '0; rem = '0; take = '0;
        b = '0; pushv = 1'b0; pbyte = '0; wmul = '0;
        baud_next = baud_reg; mode_next = mode_reg; ctrl_next = ctrl_reg;
        bcnt_next = bcnt_reg; flags_next = flags_reg; hold_next = hold_reg;
        shift_next = shift_reg; hfull_next = hfull_reg; armed_next = armed_reg;
        busy_next = busy_reg; dwait_next = dwait_reg; pend_next = pend_reg;
        tleft_next = tleft_reg; rx_next = rx_reg; head_next = head_reg;
        fill_next = fill_reg; erl_next = erl_reg; last_next = last_reg;
        dcnt_next = dcnt_reg; kind_next = kind_reg;
        result = '0;
        if (item_valid) begin
            unique case (item.req_type)
                REQ_TICK: begin
                    if (reload_v > BAUD_MAX) bcnt_next = BAUD_MAX;
                    if (reload_v == 21'd0) bcnt_next = '0;
                    else if (bcnt_reg > 21'd1) bcnt_next = bcnt_reg - 21'd1;
                    else if (bcnt_reg == 21'd0 && reload_v > 21'd1)
                        bcnt_next = reload_v - 21'd1;
                    else bcnt_next = reload_v;
                    if (dcnt_reg != 11'd0) begin
                        if (dcnt_reg == 11'd1) begin
                            dcnt_next = '0;
                            flags_next[6] = 1'b0;
                            dwait_next = 1'b1;
                        end else dcnt_next = dcnt_reg - 11'd1;
                    end
                    // start a waiting byte, then count down its shift time
                    go = !busy_reg && hfull_reg && (ctrl_reg[0] || armed_reg)
                         && (!PAD || ctrl_reg[1]) && !bitz;
                    tc = tleft_reg;
                    if (go) begin
                        shift_next = hold_reg;
                        hfull_next = 1'b0;
                        armed_next = 1'b0;
                        flags_next[0] = 1'b1;
                        tc = {1'b0, bitc, 3'b0};
                    end
                    if (busy_reg || go) begin
                        if (tc > 26'd1) begin
                            busy_next = 1'b1;
                            tleft_next = tc - 26'd1;
                        end else begin
                            result.tx_done = 1'b1;
                            result.tx_byte = go ? hold_reg : shift_reg;
                            busy_next = 1'b0;
                            tleft_next = '0;
                            if (PAD) begin
                                kind_next = kind_reg;
                                if (kind_reg == KIND_NONE) begin
                                    if (result.tx_byte == BYTE_PAD) kind_next = KIND_PAD;
                                    else if (result.tx_byte == BYTE_CARD)
                                        kind_next = KIND_CARD;
                                end
                                if (kind_next == KIND_PAD || kind_next == KIND_CARD) begin
                                    result.partner_call = kind_next;
                                    result.partner_slot = ctrl_reg[13];
                                    pend_next = 1'b1;
                                end else begin
                                    kind_next = KIND_NONE;
                                    flags_next[6] = 1'b0;
                                    pushv = 1'b1;
                                    pbyte = 8'hFF;
                                end
                            end
                            // a waiting byte starts right away with a full count
                            if (hfull_reg && (ctrl_reg[0] || armed_reg)
                                && (!PAD || ctrl_reg[1]) && !bitz) begin
                                shift_next = hold_reg;
                                hfull_next = 1'b0;
                                armed_next = 1'b0;
                                busy_next = 1'b1;
                                tleft_next = {1'b0, bitc, 3'b0};
                                flags_next[0] = 1'b1;
                            end else if (!hfull_reg) flags_next[2] = 1'b1;
                        end
                    end
                    irq_c = 1'b1;
                end
                REQ_READ: begin
                    unique case (item.reg_sel)
                        SEL_DATA: begin
                            n = (item.access_size > 3'd4) ? 3'd4 : item.access_size;
                            for (int i = 0; i < 4; i++) begin
                                b = '0;
                                if (3'(i) < n) begin
                                    if (fill_reg != 4'd0) b = rx_reg[head_reg + 3'(i)];
                                    else if ({2'b0, erl_reg} > 4'(i)) b = last_reg;
                                end
                                result.read_data[i*8 +: 8] = b;
                            end
                            rem = (item.access_size == 3'd4) ? 4'd4 : 4'd1;
                            if (fill_reg != 4'd0) begin
                                take = (rem < fill_reg) ? rem : fill_reg;
                                head_next = head_reg + rem[2:0];
                                fill_next = fill_reg - take;
                                if (fill_next == 4'd0) erl_next = 2'd2;
                            end else begin
                                erl_next = (rem >= {2'b0, erl_reg}) ? 2'd0
                                         : erl_reg - rem[1:0];
                            end
                            flags_next[1] = (fill_next != 4'd0);
                        end
                        SEL_STAT: result.read_data = {bcnt_reg, 1'b0, flags_reg[7],
                            1'b0, flags_reg[6], 1'b0, flags_reg[5:0]};
                        SEL_MODE: result.read_data = {16'b0, mode_reg};
                        SEL_CTRL: begin
                            result.read_data = {18'b0, ctrl_reg & 14'h3F2F};
                            if (ctrl_reg[7] && mode_reg[1:0] != 2'd0)
                                result.read_data[7] = 1'b1;
                        end
                        SEL_BAUD: result.read_data = {16'b0, baud_reg};
                        default: result.read_data = '0;
                    endcase
                end
                REQ_WRITE: begin
                    unique case (item.reg_sel)
                        SEL_DATA: begin
                            hold_next = item.write_value[7:0];
                            hfull_next = 1'b1;
                            armed_next = armed_reg || ctrl_reg[0];
                            flags_next[0] = 1'b0;
                            flags_next[2] = 1'b0;
                        end
                        SEL_MODE: mode_next = item.write_value;
                        SEL_CTRL: begin
                            ctrl_next = item.write_value[13:0] & 14'h3FAF;
                            if (item.write_value[4]) begin
                                flags_next[3] = 1'b0; flags_next[4] = 1'b0;
                                flags_next[5] = 1'b0; flags_next[7] = 1'b0;
                            end
                            if (item.write_value[6]) begin
                                baud_next = '0; mode_next = '0; ctrl_next = '0;
                                bcnt_next = '0; flags_next = 8'h05; hold_next = '0;
                                shift_next = '0; tleft_next = '0; hfull_next = 1'b0;
                                armed_next = 1'b0; busy_next = 1'b0;
                                dwait_next = 1'b0; pend_next = 1'b0;
                                for (int i = 0; i < 8; i++) rx_next[i] = '0;
                                head_next = '0; fill_next = '0; erl_next = '0;
                                last_next = '0; dcnt_next = '0; kind_next = KIND_NONE;
                                result.partner_reset = PAD;
                            end else if (!PAD && !ctrl_next[2]) begin
                                head_next = '0; fill_next = '0; flags_next[1] = 1'b0;
                            end else if (PAD && !ctrl_next[1]) begin
                                kind_next = KIND_NONE; pend_next = 1'b0;
                                flags_next[6] = 1'b0; result.partner_reset = 1'b1;
                            end
                        end
                        SEL_BAUD: begin
                            baud_next = item.write_value;
                            unique case (mode_reg[1:0])
                                2'd2: wmul = PAD ? {2'b0, item.write_value, 4'b0}
                                           : {6'b0, item.write_value};
                                2'd3: wmul = PAD ? {item.write_value, 6'b0}
                                           : {6'b0, item.write_value};
                                default: wmul = {6'b0, item.write_value};
                            endcase
                            bcnt_next = wmul[21:1];
                        end
                        default: ;
                    endcase
                end
                REQ_RESP: begin
                    if (pend_reg) begin
                        pend_next = 1'b0;
                        flags_next[6] = item.resp_dsr;
                        if (item.resp_dsr)
                            dcnt_next = (kind_reg == KIND_PAD) ? DSR_PAD : DSR_CARD;
                        else kind_next = KIND_NONE;
                        pushv = 1'b1;
                        pbyte = item.resp_byte;
                        irq_c = 1'b1;
                    end
                end
                default: ;
            endcase
            if (pushv) begin
                if (fill_reg[3]) begin
                    rx_next[head_reg - 3'd1] = pbyte;
                    if (!PAD) flags_next[4] = 1'b1;
                end else begin
                    for (int i = 0; i < 8; i++)
                        if (4'(i) >= fill_reg) rx_next[head_reg + 3'(i)] = pbyte;
                    fill_next = fill_reg + 4'd1;
                end
                last_next = pbyte;
                erl_next = 2'd2;
                flags_next[1] = 1'b1;
            end
            if (irq_c) begin
                thr = 4'd1 << ctrl_next[9:8];
                if (((ctrl_next[10] && (flags_next[0] || flags_next[2]))
                     || (ctrl_next[11] && fill_next >= thr)
                     || (ctrl_next[12] && dwait_next)) && !flags_next[7]) begin
                    flags_next[7] = 1'b1;
                    dwait_next = 1'b0;
                    result.irq_pulse = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            baud_reg <= '0; mode_reg <= '0; ctrl_reg <= '0; bcnt_reg <= '0;
            flags_reg <= 8'h05; hold_reg <= '0; shift_reg <= '0; tleft_reg <= '0;
            hfull_reg <= 1'b0; armed_reg <= 1'b0; busy_reg <= 1'b0;
            dwait_reg <= 1'b0; pend_reg <= 1'b0;
            for (int i = 0; i < 8; i++) rx_reg[i] <= '0;
            head_reg <= '0; fill_reg <= '0; erl_reg <= '0; last_reg <= '0;
            dcnt_reg <= '0; kind_reg <= KIND_NONE;
        end else begin
            baud_reg <= baud_next; mode_reg <= mode_next; ctrl_reg <= ctrl_next;
            bcnt_reg <= bcnt_next; flags_reg <= flags_next; hold_reg <= hold_next;
            shift_reg <= shift_next; tleft_reg <= tleft_next;
            hfull_reg <= hfull_next; armed_reg <= armed_next; busy_reg <= busy_next;
            dwait_reg <= dwait_next; pend_reg <= pend_next; rx_reg <= rx_next;
            head_reg <= head_next; fill_reg <= fill_next; erl_reg <= erl_next;
            last_reg <= last_next; dcnt_reg <= dcnt_next; kind_reg <= kind_next;
        end
    end

    `ASSERT_IMPL(a_fill_max, aclk, aresetn, 1'b1, fill_reg <= 4'd8, "rx fill over depth")
    `ASSERT_IMPL(a_busy_left, aclk, aresetn, busy_reg, tleft_reg != 26'd0,
        "busy with no cycles left")
    `ASSERT_IMPL(a_pend_kind, aclk, aresetn, pend_reg, kind_reg != KIND_NONE,
        "call pending without partner")
endmodule
`default_nettype wire

// ----- design/serial_port_channel.sv -----
// ---------------------------------------------------------------------------
// serial_port_channel
// Register-mapped serial channel with partner exchange on the result side.
// ---------------------------------------------------------------------------
// channel  dir  fields
// s_axis   in   tdata: req_type, reg_sel, access_size, write_value, resp_byte, resp_dsr
// m_axis   out  tdata: read_data, irq_pulse, tx_done, tx_byte, partner_call, slot, reset
// One transfer per cycle; each result appears in the cycle after its input.
// The result register holds while m_tready is low; s_tready follows it,
// so a stalled result stalls input. Synchronous reset, no clearing pass.
`default_nettype none
`include "assert_macros.svh"
module serial_port_channel #(
    parameter int IS_PAD_PORT = spc_pkg::IS_PAD_PORT_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // req_type[1:0] reg_sel[4:2] access_size[7:5] write_value[23:8]
    // resp_byte[31:24] resp_dsr[32]
    input  wire logic [39:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // read_data[31:0] irq_pulse[32] tx_done[33] tx_byte[41:34]
    // partner_call[43:42] partner_slot[44] partner_reset[45]
    output logic [47:0]      m_tdata
);
    import spc_pkg::*;

    item_t   item;
    result_t res;
    logic    acc;
    result_t res_reg;
    logic    vld_reg;

    assign s_tready = !vld_reg || m_tready;
    assign acc = s_tvalid && s_tready;
    assign item = s_tdata[32:0];

    spc_core #(.IS_PAD_PORT(IS_PAD_PORT)) u_core (
        .aclk(aclk), .aresetn(aresetn), .item_valid(acc), .item(item), .result(res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else if (s_tready) begin
            vld_reg <= acc;
        end
        if (acc) res_reg <= res;
    end

    assign m_tvalid = vld_reg;
    assign m_tdata = {2'b0, res_reg};

    `ASSERT_NEXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid,
        "result dropped while stalled")
    `ASSERT_IMPL(a_rdy, aclk, aresetn, !m_tvalid, s_tready, "not ready while empty")
endmodule
`default_nettype wire
